FILE: rtl/bur_pkg.sv
`default_nettype none

package bur_pkg;

   localparam int DEF_RX_DEPTH = 256;
   localparam int DEF_TX_DEPTH = 256;

   localparam int BYTE_W = 8;
   localparam int CNT_W  = 16;
   localparam int ACT_W  = 2;

   localparam logic [ACT_W-1:0] ACT_SERVICE = 2'd0;
   localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 72;

   // queue flags before the step and after it
   typedef struct packed {
      logic empty;
      logic full;
      logic empty_after;
      logic full_after;
   } ring_status_type;

endpackage

`default_nettype wire

FILE: rtl/bur_ram.sv
`default_nettype none

module bur_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bur_ring.sv
`default_nettype none

module bur_ring
   import bur_pkg::*;
#(
   parameter int DEPTH = DEF_RX_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [BYTE_W-1:0] push_data,
   input  wire logic              pop,
   output ring_status_type        status,
   output logic      [BYTE_W-1:0] pop_data
);

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;

   function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
      if (p == LAST) begin
         advance = '0;
      end else begin
         advance = p + 1'b1;
      end
   endfunction

   assign wr_ptr_in = push ? advance(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop  ? advance(rd_ptr_ff) : rd_ptr_ff;

   // one slot stays empty
   assign status.empty       = (wr_ptr_ff == rd_ptr_ff);
   assign status.full        = (advance(wr_ptr_ff) == rd_ptr_ff);
   assign status.empty_after = (wr_ptr_in == rd_ptr_in);
   assign status.full_after  = (advance(wr_ptr_in) == rd_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   bur_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_en   (pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (pop_data)
   );

`ifndef SYNTHESIS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full ring");
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty ring");
`endif

endmodule

`default_nettype wire

FILE: rtl/buffered_uart_ring_queues.sv
// buffered uart ring queues
// receive and transmit byte rings of an interrupt-driven uart, kept in two
// synchronous rams (one per ring), each ring keeping one slot empty
// request channel (req_*): req_tuser carries the action (service, cpu write,
// cpu read), req_tdata carries the byte and the receiver/transmitter flags
// response channel (rsp_*): exactly one response per request, in order,
// carrying read data, transmit byte, queue flags, the three wrapping 16-bit
// tallies and the transmit interrupt arm
// pipeline: pointer update and ram read happen at the accepting edge,
// together with the middle stage capture; the output register is loaded
// when the middle stage advances, and the response is then valid
// throughput: one request per cycle unless stalled (see below); pointers and
// tallies update at the accepting edge, so the next request already sees them
// stall: while rsp_tready is low the response holds, one more request may be
// taken into the middle stage, then req_tready drops until the output moves
// reset: synchronous, active high; pointers, tallies, arm and valid flags go
// to zero, ram contents stay undefined and are never read before written
`default_nettype none

module buffered_uart_ring_queues
   import bur_pkg::*;
#(
   parameter int RX_DEPTH = DEF_RX_DEPTH,
   parameter int TX_DEPTH = DEF_TX_DEPTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] byte_in, [8] overrun_flag, [9] rx_ready_flag, [10] tx_ready_flag,
   // [15:11] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  wire logic [ACT_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] read_valid, [8:1] read_data, [9] write_accepted, [10] tx_send,
   // [18:11] tx_data, [19] rx_nonempty, [20] tx_queue_empty,
   // [21] tx_queue_full, [37:22] rx_drop_count, [53:38] rx_overrun_count,
   // [69:54] tx_drop_count, [70] tx_irq_armed, [71] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   // middle stage: everything but the ram data, which the ram registers itself at the same edge
   typedef struct packed {
      logic             rd_valid;
      logic             wr_ok;
      logic             send;
      logic             rx_nonempty;
      logic             tx_empty;
      logic             tx_full;
      logic [CNT_W-1:0] rx_drop;
      logic [CNT_W-1:0] rx_ovr;
      logic [CNT_W-1:0] tx_drop;
      logic             armed;
   } stage_type;

   // request fields
   logic [BYTE_W-1:0] byte_in;
   logic              ovr_flag;
   logic              rxr_flag;
   logic              txr_flag;
   logic              req_fire;
   logic              is_svc, is_wr, is_rd;

   assign byte_in  = req_tdata[BYTE_W-1:0];
   assign ovr_flag = req_tdata[8];
   assign rxr_flag = req_tdata[9];
   assign txr_flag = req_tdata[10];

   // pipeline control
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   logic      s1_adv;
   logic      rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   assign is_svc = req_fire && (req_tuser == ACT_SERVICE);
   assign is_wr  = req_fire && (req_tuser == ACT_WRITE);
   assign is_rd  = req_fire && (req_tuser == ACT_READ);

   logic [CNT_W-1:0] rx_drop_ff, rx_drop_in;
   logic [CNT_W-1:0] rx_ovr_ff, rx_ovr_in;
   logic [CNT_W-1:0] tx_drop_ff, tx_drop_in;
   logic             tx_irq_ff, tx_irq_in;

   // ring queues
   ring_status_type   rx_st, tx_st;
   logic              rx_push, rx_pop, tx_push, tx_pop;
   logic [BYTE_W-1:0] rx_q, tx_q;

   // overrun wins over a ready byte
   assign rx_push = is_svc && !ovr_flag && rxr_flag && !rx_st.full;
   assign rx_pop  = is_rd && !rx_st.empty;
   assign tx_pop  = is_svc && txr_flag && tx_irq_ff && !tx_st.empty;
   assign tx_push = is_wr && !tx_st.full;

   bur_ring #(
      .DEPTH (RX_DEPTH)
   ) u_rx_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (rx_push),
      .push_data (byte_in),
      .pop       (rx_pop),
      .status    (rx_st),
      .pop_data  (rx_q)
   );

   bur_ring #(
      .DEPTH (TX_DEPTH)
   ) u_tx_ring (
      .clock     (clock),
      .reset     (reset),
      .push      (tx_push),
      .push_data (byte_in),
      .pop       (tx_pop),
      .status    (tx_st),
      .pop_data  (tx_q)
   );

   // tallies and interrupt arm
   always_comb begin
      rx_drop_in = rx_drop_ff;
      rx_ovr_in  = rx_ovr_ff;
      tx_drop_in = tx_drop_ff;
      tx_irq_in  = tx_irq_ff;
      if (is_svc && ovr_flag) begin
         rx_ovr_in = rx_ovr_ff + 1'b1;
      end
      if (is_svc && !ovr_flag && rxr_flag && rx_st.full) begin
         rx_drop_in = rx_drop_ff + 1'b1;
      end
      // transmitter ready with nothing queued: disarm
      if (is_svc && txr_flag && tx_irq_ff && tx_st.empty) begin
         tx_irq_in = 1'b0;
      end
      if (is_wr && tx_st.full) begin
         tx_drop_in = tx_drop_ff + 1'b1;
      end
      if (tx_push) begin
         tx_irq_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_drop_ff <= '0;
         rx_ovr_ff  <= '0;
         tx_drop_ff <= '0;
         tx_irq_ff  <= 1'b0;
      end else begin
         rx_drop_ff <= rx_drop_in;
         rx_ovr_ff  <= rx_ovr_in;
         tx_drop_ff <= tx_drop_in;
         tx_irq_ff  <= tx_irq_in;
      end
   end

   // middle stage capture
   always_comb begin
      s1_in.rd_valid    = rx_pop;
      s1_in.wr_ok       = tx_push;
      s1_in.send        = tx_pop;
      s1_in.rx_nonempty = !rx_st.empty_after;
      s1_in.tx_empty    = tx_st.empty_after;
      s1_in.tx_full     = tx_st.full_after;
      s1_in.rx_drop     = rx_drop_in;
      s1_in.rx_ovr      = rx_ovr_in;
      s1_in.tx_drop     = tx_drop_in;
      s1_in.armed       = tx_irq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
   end

   // response word; ram data held since no new pop happens while stalled
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[0]     = s1_ff.rd_valid;
      rsp_data_in[8:1]   = s1_ff.rd_valid ? rx_q : '0;
      rsp_data_in[9]     = s1_ff.wr_ok;
      rsp_data_in[10]    = s1_ff.send;
      rsp_data_in[18:11] = s1_ff.send ? tx_q : '0;
      rsp_data_in[19]    = s1_ff.rx_nonempty;
      rsp_data_in[20]    = s1_ff.tx_empty;
      rsp_data_in[21]    = s1_ff.tx_full;
      rsp_data_in[37:22] = s1_ff.rx_drop;
      rsp_data_in[53:38] = s1_ff.rx_ovr;
      rsp_data_in[69:54] = s1_ff.tx_drop;
      rsp_data_in[70]    = s1_ff.armed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_read_hit: assert property (@(posedge clock) disable iff (reset)
      (is_rd && !rx_st.empty) |=> (s1_valid_ff && s1_ff.rd_valid))
      else $error("read of nonempty receive ring lost its byte");
   a_write_arms: assert property (@(posedge clock) disable iff (reset)
      (is_wr && !tx_st.full) |=> tx_irq_ff)
      else $error("accepted write did not arm transmit interrupt");
   a_disarm_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(tx_irq_ff) |-> ($past(reset) || $past(is_svc && txr_flag && tx_st.empty)))
      else $error("transmit interrupt disarmed without empty service");
   a_send_armed: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ff.send) |-> $past(tx_irq_ff))
      else $error("byte sent while transmit interrupt disarmed");
`endif

endmodule

`default_nettype wire
